>>> hw/rtl/wbss_pkg.sv
`default_nettype none
package wbss_pkg;

  localparam int MAX_PATTERN_DEF  = 32;
  localparam int ADDRESS_BITS_DEF = 48;

  localparam int PAT_SLOTS   = 32;  // byte slots held by the four pattern registers
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int LEN_W       = 6;
  localparam int WILD_W      = 32;
  localparam int ADDR_FIELD_W = 48;

  typedef logic [7:0] byte_t;
  typedef logic [PAT_SLOTS*8-1:0] pat_flat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO   = 3'd0,
    CFG_PAT_MID  = 3'd1,
    CFG_PAT_HIGH = 3'd2,
    CFG_PAT_TOP  = 3'd3,
    CFG_WILD     = 3'd4,
    CFG_LEN      = 3'd5
  } cfg_idx_t;

  // what one window cell needs to judge its byte
  typedef struct packed {
    logic  pass;  // position unused or wildcard
    byte_t pat;
  } cell_ctl_t;

  function automatic byte_t pattern_at(input pat_flat_t flat, input logic [4:0] pos);
    pattern_at = flat[pos*8 +: 8];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/wbss_cell.sv
`default_nettype none
module wbss_cell
  import wbss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      shift_en,
  input  wire byte_t     byte_in,
  input  wire cell_ctl_t ctl,
  output byte_t          byte_r,
  output logic           hit
);

  byte_t byte_nxt;

  always_comb begin
    byte_nxt = shift_en ? byte_in : byte_r;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign hit = ctl.pass | (byte_in == ctl.pat);

endmodule
`default_nettype wire

>>> hw/rtl/wildcard_byte_signature_scanner.sv
// Channel | Dir | Fields                                           | Handshake
// in      | in  | data_byte, byte_address, region_first, scan_last | in_valid/in_ready
// out     | out | found, match_address                             | out_valid/out_ready
// cfg     | in  | cfg_index, cfg_wr_data                           | cfg_wr_en, no wait
//
// One byte beat per cycle while in_ready is high. The result of a beat is registered
// and shows on out in the cycle after it is accepted; every window cell compares in
// the same cycle, so the match over MAX_PATTERN bytes is one compare plus one AND tree.
// Reset (sync, rst_n low) clears config, fill count, the reported flag and out_valid.
// While a result waits with out_ready low, in_ready stays low.
`default_nettype none
module wildcard_byte_signature_scanner
  import wbss_pkg::*;
#(
  parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_data_byte,
  input  wire logic [ADDR_FIELD_W-1:0] in_byte_address,
  input  wire logic                    in_region_first,
  input  wire logic                    in_scan_last,

  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_found,
  output logic [ADDR_FIELD_W-1:0]      out_match_address,

  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wr_data
);

  localparam int FW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [FW-1:0] FILL_MAX = FW'(MAX_PATTERN - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);
  localparam logic [63:0] AMASK = {64{1'b1}} >> (64 - ADDRESS_BITS);

  // configuration
  logic [CFG_DATA_W-1:0] pat_lo_r, pat_mid_r, pat_high_r, pat_top_r;
  logic [WILD_W-1:0]     wild_r;
  logic [LEN_W-1:0]      len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r   <= '0;
      pat_mid_r  <= '0;
      pat_high_r <= '0;
      pat_top_r  <= '0;
      wild_r     <= '0;
      len_r      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PAT_LO:   pat_lo_r   <= cfg_wr_data;
        CFG_PAT_MID:  pat_mid_r  <= cfg_wr_data;
        CFG_PAT_HIGH: pat_high_r <= cfg_wr_data;
        CFG_PAT_TOP:  pat_top_r  <= cfg_wr_data;
        CFG_WILD:     wild_r     <= cfg_wr_data[WILD_W-1:0];
        CFG_LEN:      len_r      <= cfg_wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  pat_flat_t pat_flat;
  assign pat_flat = {pat_top_r, pat_high_r, pat_mid_r, pat_lo_r};

  // scan control
  logic          in_fire, shift_en, match, emit;
  logic          reported_r, reported_nxt;
  logic [FW-1:0] fill_r, fill_nxt, fill_eff;
  logic          out_valid_r, out_valid_nxt;
  logic          found_r;
  logic [ADDR_FIELD_W-1:0] addr_r;

  // window: chain[a] is the byte of age a, chain[0] the current one
  byte_t                  chain [0:MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;

  assign chain[0] = in_data_byte;

  for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_cell
    logic [LEN_W-1:0] pos;
    cell_ctl_t        ctl;

    // pattern position that lines up with age a
    assign pos      = LEN_W'(len_r - LEN_W'(1) - LEN_W'(a));
    assign ctl.pass = (LEN_W'(a) >= len_r) | wild_r[pos[4:0]];
    assign ctl.pat  = pattern_at(pat_flat, pos[4:0]);

    wbss_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .byte_in  (chain[a]),
      .ctl      (ctl),
      .byte_r   (chain[a+1]),
      .hit      (hit[a])
    );
  end

  logic             len_ok, fill_ok;
  logic [LEN_W-1:0] fill_cnt;
  logic [63:0]      start_addr;

  assign fill_eff = in_region_first ? '0 : fill_r;
  assign fill_cnt = LEN_W'(fill_eff) + LEN_W'(1);   // bytes in region incl. current
  assign len_ok   = (len_r != '0) && (len_r <= LEN_MAX);
  assign fill_ok  = fill_cnt >= len_r;
  assign match    = len_ok && fill_ok && (&hit);

  assign start_addr = (64'(in_byte_address) - 64'(len_r - LEN_W'(1))) & AMASK;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign shift_en = in_fire && !reported_r && !match;
  assign emit     = in_fire && !reported_r && (match || in_scan_last);

  always_comb begin
    fill_nxt     = fill_r;
    reported_nxt = reported_r;
    if (in_fire) begin
      if (!reported_r) begin
        if (match) begin
          fill_nxt     = fill_eff;
          reported_nxt = 1'b1;
        end else begin
          fill_nxt = (fill_eff < FILL_MAX) ? fill_eff + FW'(1) : fill_eff;
        end
      end
      if (in_scan_last) begin
        fill_nxt     = '0;
        reported_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found_r <= match;
      addr_r  <= match ? start_addr[ADDR_FIELD_W-1:0] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_match_address = addr_r;

endmodule
`default_nettype wire

>>> hw/rtl/wbss_checker.sv
`default_nettype none
module wbss_checker
  import wbss_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic                    out_found,
  input wire logic [ADDR_FIELD_W-1:0] out_match_address
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_match_address))
    else $error("result changed while stalled");

  // scan-end beat carries a zero address
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_address == '0)
    else $error("no-match result with nonzero address");

  // output register empty means input is open
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // nothing appears without an accepted input beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("result without an input beat");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind wildcard_byte_signature_scanner wbss_checker u_wbss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_found         (out_found),
  .out_match_address (out_match_address)
);
`default_nettype wire
